### design/bounded_fifo_lifo_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded FIFO/LIFO queue
// Shorthand for the concurrent checks used inside the design modules.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_FIFO_LIFO_QUEUE_MACROS_SVH
`define BOUNDED_FIFO_LIFO_QUEUE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define BFLQ_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BFLQ_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFLQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bflq_pkg.sv
// ----------------------------------------------------------------------------
// bflq_pkg
// Command, status, policy and register codes plus shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bflq_pkg;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_TRY   = 3'd2;
    localparam logic [2:0] CMD_PEEK  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_EMPTY   = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_BADLEN  = 3'd3;
    localparam logic [2:0] STAT_OVERLAP = 3'd4;
    localparam logic [2:0] STAT_DROPPED = 3'd5;

    localparam logic [1:0] POL_GROW     = 2'd0;
    localparam logic [1:0] POL_DROP_NEW = 2'd1;
    localparam logic [1:0] POL_DROP_OLD = 2'd2;

    localparam logic [1:0] REG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_LIFO   = 2'd1;
    localparam logic [1:0] REG_INDEX  = 2'd2;
    localparam logic [1:0] REG_POLICY = 2'd3;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_TRY,
        OP_PEEK,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic len_zero;
    } class_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } state_t;

endpackage

### design/bflq_front.sv
// ----------------------------------------------------------------------------
// bflq_front
// Accepts command beats, decodes them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bflq_front #(
    parameter int HW = 32,
    parameter int LW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           cmd,
    input  logic [HW-1:0]        handle,
    input  logic [LW-1:0]        entry_length,
    output logic                 q_valid,
    input  logic                 q_take,
    output bflq_pkg::class_t     q_cls,
    output logic [HW-1:0]        q_handle,
    output logic [LW-1:0]        q_length
);

    bflq_pkg::class_t cls;
    bflq_pkg::class_t cls_reg [2];
    logic [HW-1:0]    handle_reg [2];
    logic [LW-1:0]    len_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             push;

    always_comb
    begin
        cls.len_zero = (entry_length == '0);
        unique case (cmd)
            bflq_pkg::CMD_WRITE: cls.op = bflq_pkg::OP_WRITE;
            bflq_pkg::CMD_READ:  cls.op = bflq_pkg::OP_READ;
            bflq_pkg::CMD_TRY:   cls.op = bflq_pkg::OP_TRY;
            bflq_pkg::CMD_PEEK:  cls.op = bflq_pkg::OP_PEEK;
            bflq_pkg::CMD_CLEAR: cls.op = bflq_pkg::OP_CLEAR;
            default:             cls.op = bflq_pkg::OP_NOP;
        endcase
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cls    = cls_reg[rd_ptr_reg];
    assign q_handle = handle_reg[rd_ptr_reg];
    assign q_length = len_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_take ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(q_take);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cls_reg[wr_ptr_reg]    <= cls;
            handle_reg[wr_ptr_reg] <= handle;
            len_reg[wr_ptr_reg]    <= entry_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### design/bflq_back.sv
// ----------------------------------------------------------------------------
// bflq_back
// Executes queued commands against the entry memory and registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_fifo_lifo_queue_macros.svh"

module bflq_back #(
    parameter int DEPTH = 256,
    parameter int HW    = 32,
    parameter int LW    = 16,
    parameter int CW    = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_take,
    input  bflq_pkg::class_t     q_cls,
    input  logic [HW-1:0]        q_handle,
    input  logic [LW-1:0]        q_length,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [CW-1:0]        cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [HW-1:0]        out_handle,
    output logic [LW-1:0]        out_length,
    output logic [CW-1:0]        entry_count,
    output logic                 is_empty,
    output logic                 is_full,
    output logic [CW-1:0]        room_left
);

    localparam int AW = $clog2(DEPTH);
    localparam int XW = (HW > LW) ? HW : LW;

    // Entry memory, handle in the upper bits and length in the lower bits.
    logic [HW+LW-1:0] mem [DEPTH];
    logic [HW+LW-1:0] rd_data_reg;
    logic             we, rd_en;
    logic [AW-1:0]    waddr, raddr;

    bflq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    scan_k_reg, scan_k_next;
    bflq_pkg::op_t    cur_op_reg, cur_op_next;
    logic [HW-1:0]    cur_handle_reg, cur_handle_next;
    logic [LW-1:0]    cur_len_reg, cur_len_next;

    logic [CW-1:0]    limit_reg;
    logic             lifo_reg, index_reg;
    logic [1:0]       policy_reg;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg, status_next;
    logic [HW-1:0]    out_handle_reg, out_handle_next;
    logic [LW-1:0]    out_length_reg, out_length_next;
    logic [CW-1:0]    count_out_reg;

    logic             out_free, ld_out;
    logic [CW-1:0]    lim;
    logic [HW-1:0]    rd_handle, diff_da, diff_ad;
    logic [LW-1:0]    rd_len;
    logic             no_ov_low, no_ov_high, overlap;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(k);
        if (sum >= (CW+1)'(DEPTH))
            sum = sum - (CW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

    assign lim = (limit_reg == '0 || limit_reg > CW'(DEPTH)) ? CW'(DEPTH) : limit_reg;
    assign out_free = !out_valid_reg || !out_stall;

    assign rd_handle = rd_data_reg[HW+LW-1:LW];
    assign rd_len    = rd_data_reg[LW-1:0];
    assign diff_da   = rd_handle - cur_handle_reg;
    assign diff_ad   = cur_handle_reg - rd_handle;
    // The stored range includes its end point; the probed range does not.
    assign no_ov_low  = (cur_handle_reg <= rd_handle) && (XW'(cur_len_reg) <= XW'(diff_da));
    assign no_ov_high = (cur_handle_reg > rd_handle) && (XW'(diff_ad) > XW'(rd_len));
    assign overlap    = !(no_ov_low || no_ov_high);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        scan_k_next     = scan_k_reg;
        cur_op_next     = cur_op_reg;
        cur_handle_next = cur_handle_reg;
        cur_len_next    = cur_len_reg;
        q_take          = 1'b0;
        we              = 1'b0;
        waddr           = slot_of(head_reg, count_reg);
        rd_en           = 1'b0;
        raddr           = head_reg;
        ld_out          = 1'b0;
        status_next     = bflq_pkg::STAT_OK;
        out_handle_next = '0;
        out_length_next = '0;

        unique case (state_reg)
            bflq_pkg::S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_take          = 1'b1;
                    cur_op_next     = q_cls.op;
                    cur_handle_next = q_handle;
                    cur_len_next    = q_length;
                    ld_out          = 1'b1;
                    case (q_cls.op)
                        bflq_pkg::OP_WRITE:
                        begin
                            if (q_cls.len_zero)
                                status_next = bflq_pkg::STAT_BADLEN;
                            else if (policy_reg == bflq_pkg::POL_DROP_OLD)
                            begin
                                we              = 1'b1;
                                out_length_next = q_length;
                                if (count_reg >= lim)
                                begin
                                    head_next   = slot_of(head_reg, CW'(1));
                                    status_next = bflq_pkg::STAT_DROPPED;
                                end
                                else
                                    count_next = count_reg + 1'b1;
                            end
                            else if ((policy_reg == bflq_pkg::POL_DROP_NEW && count_reg >= lim)
                                     || count_reg >= CW'(DEPTH))
                                status_next = bflq_pkg::STAT_FULL;
                            else
                            begin
                                we              = 1'b1;
                                out_length_next = q_length;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        bflq_pkg::OP_READ, bflq_pkg::OP_PEEK:
                        begin
                            if (count_reg == '0)
                                status_next = bflq_pkg::STAT_EMPTY;
                            else
                            begin
                                ld_out     = 1'b0;
                                rd_en      = 1'b1;
                                raddr      = lifo_reg ? slot_of(head_reg, count_reg - 1'b1)
                                                      : head_reg;
                                state_next = bflq_pkg::S_READ;
                            end
                        end
                        bflq_pkg::OP_TRY:
                        begin
                            if (q_cls.len_zero)
                                status_next = bflq_pkg::STAT_BADLEN;
                            else if (count_reg >= lim)
                                status_next = bflq_pkg::STAT_FULL;
                            else if (index_reg && count_reg != '0)
                            begin
                                ld_out      = 1'b0;
                                rd_en       = 1'b1;
                                raddr       = head_reg;
                                scan_k_next = '0;
                                state_next  = bflq_pkg::S_SCAN;
                            end
                        end
                        bflq_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bflq_pkg::S_READ:
            begin
                ld_out          = 1'b1;
                out_length_next = rd_len;
                state_next      = bflq_pkg::S_IDLE;
                if (cur_op_reg == bflq_pkg::OP_READ)
                begin
                    out_handle_next = rd_handle;
                    count_next      = count_reg - 1'b1;
                    if (!lifo_reg)
                        head_next = slot_of(head_reg, CW'(1));
                end
            end
            bflq_pkg::S_SCAN:
            begin
                // Read data always belongs to entry scan_k_reg.
                if (overlap)
                begin
                    ld_out      = 1'b1;
                    status_next = bflq_pkg::STAT_OVERLAP;
                    state_next  = bflq_pkg::S_IDLE;
                end
                else if (scan_k_reg + 1'b1 == count_reg)
                begin
                    ld_out     = 1'b1;
                    state_next = bflq_pkg::S_IDLE;
                end
                else
                begin
                    rd_en       = 1'b1;
                    raddr       = slot_of(head_reg, scan_k_reg + 1'b1);
                    scan_k_next = scan_k_reg + 1'b1;
                end
            end
            default:
                state_next = bflq_pkg::S_IDLE;
        endcase

        if (ld_out)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= {q_handle, q_length};
        if (rd_en)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg     <= cur_op_next;
        cur_handle_reg <= cur_handle_next;
        cur_len_reg    <= cur_len_next;
        scan_k_reg     <= scan_k_next;
        if (ld_out)
        begin
            status_reg     <= status_next;
            out_handle_reg <= out_handle_next;
            out_length_reg <= out_length_next;
            count_out_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bflq_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= '0;
            lifo_reg      <= 1'b0;
            index_reg     <= 1'b0;
            policy_reg    <= bflq_pkg::POL_GROW;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bflq_pkg::REG_LIMIT:  limit_reg  <= cfg_data;
                    bflq_pkg::REG_LIFO:   lifo_reg   <= cfg_data[0];
                    bflq_pkg::REG_INDEX:  index_reg  <= cfg_data[0];
                    bflq_pkg::REG_POLICY: policy_reg <= cfg_data[1:0];
                    default:              limit_reg  <= limit_reg;
                endcase
            end
        end
    end

    // The full flag and room_left are taken against the limit in force now.
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_handle  = out_handle_reg;
    assign out_length  = out_length_reg;
    assign entry_count = count_out_reg;
    assign is_empty    = (count_out_reg == '0);
    assign is_full     = (count_out_reg >= lim);
    assign room_left   = (lim > count_out_reg) ? (lim - count_out_reg) : '0;

    `BFLQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "count above depth")
    `BFLQ_ASSERT_IMPLIES(a_scan_range, clk, rst_n, state_reg == bflq_pkg::S_SCAN, scan_k_reg < count_reg, "scan past count")
    `BFLQ_ASSERT_IMPLIES(a_take_idle, clk, rst_n, q_take, state_reg == bflq_pkg::S_IDLE && out_free, "take while busy")
    `BFLQ_ASSERT_NEXT(a_read_done, clk, rst_n, state_reg == bflq_pkg::S_READ, out_valid_reg && state_reg == bflq_pkg::S_IDLE, "read result missing")

endmodule

### design/bounded_fifo_lifo_queue.sv
// ----------------------------------------------------------------------------
// bounded_fifo_lifo_queue
// Single-channel bounded message queue with FIFO/LIFO order and drop policy.
// ----------------------------------------------------------------------------
// Usage: command beats (cmd, handle, entry_length) enter on in_valid/in_stall;
// each produces exactly one result beat on out_valid/out_stall. Configuration
// registers (limit, LIFO, index mode, policy) are written on cfg_valid/
// cfg_ready, which is always ready; write them only while the queue is idle.
// A two-entry command queue decouples the input from the execution unit, so
// input beats are taken while a result waits.
// Timing: a beat accepted at one edge is taken by the execution unit once it
// is idle and the output is free, and the edge that ends its execution also
// loads the output register. Write, clear, try without index scan and refused
// commands execute in the cycle in which they are taken; read and peek pass
// through the registered memory read port (S_READ); try in index mode compares
// one stored entry per cycle in S_SCAN, ending early on an overlap. Commands
// without read or scan sustain one beat per cycle while out_stall is low.
// Reset clears the queue, state and config; result registers and entry memory
// are not cleared; the memory needs no clearing pass. A high out_stall holds
// the result, pauses execution and fills the command queue, raising in_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_fifo_lifo_queue #(
    parameter int DEPTH        = 256,
    parameter int HANDLE_WIDTH = 32,
    parameter int LENGTH_WIDTH = 16,
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              cmd,
    input  logic [HANDLE_WIDTH-1:0] handle,
    input  logic [LENGTH_WIDTH-1:0] entry_length,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic [HANDLE_WIDTH-1:0] out_handle,
    output logic [LENGTH_WIDTH-1:0] out_length,
    output logic [CW-1:0]           entry_count,
    output logic                    is_empty,
    output logic                    is_full,
    output logic [CW-1:0]           room_left,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [CW-1:0]           cfg_data
);

    logic                    q_valid;
    logic                    q_take;
    bflq_pkg::class_t        q_cls;
    logic [HANDLE_WIDTH-1:0] q_handle;
    logic [LENGTH_WIDTH-1:0] q_length;

    assign cfg_ready = 1'b1;

    bflq_front #(
        .HW(HANDLE_WIDTH),
        .LW(LENGTH_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .handle       (handle),
        .entry_length (entry_length),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_cls        (q_cls),
        .q_handle     (q_handle),
        .q_length     (q_length)
    );

    bflq_back #(
        .DEPTH(DEPTH),
        .HW   (HANDLE_WIDTH),
        .LW   (LENGTH_WIDTH),
        .CW   (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_cls       (q_cls),
        .q_handle    (q_handle),
        .q_length    (q_length),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_handle  (out_handle),
        .out_length  (out_length),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .room_left   (room_left)
    );

endmodule
